// ===== sv/pcb_pkg.sv =====
// Shared constants, codes and types of the correlation / beta unit.
package pcb_pkg;

   localparam int COUNT_BITS_DEF  = 20;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int RESULT_BITS     = 24;
   localparam int FRAC_BITS       = 16;
   localparam int QUOT_BITS       = 48;
   localparam int ROOT_BITS       = 24;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_ADDR_BITS   = 1;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_FINISH = 1'b1;
   localparam logic MODE_CORR   = 1'b0;
   localparam logic MODE_BETA   = 1'b1;

   localparam logic [CSR_ADDR_BITS-1:0] REG_MODE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_SAT,
      ST_DIV,
      ST_SQRT,
      ST_FINAL,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] result;
      logic                          result_valid;
      logic                          samples_dropped;
   } rsp_payload_type;

   typedef struct packed {
      logic push;
      logic full;
      logic pop;
      logic empty;
   } queue_ctrl_type;

endpackage

// ===== sv/pcb_stream_if.sv =====
// Request and response channel interfaces of the correlation / beta unit.
interface pcb_req_if #(
   parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [SAMPLE_BITS-1:0] sample_a;
   logic signed [SAMPLE_BITS-1:0] sample_b;
   logic                          a_present;
   logic                          b_present;

   modport source (output valid, kind, sample_a, sample_b, a_present, b_present,
                   input ready);
   modport sink (input valid, kind, sample_a, sample_b, a_present, b_present,
                 output ready);
endinterface

interface pcb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcb_pkg::RESULT_BITS-1:0] result;
   logic                                   result_valid;
   logic                                   samples_dropped;

   modport source (output valid, result, result_valid, samples_dropped, input ready);
   modport sink (input valid, result, result_valid, samples_dropped, output ready);
endinterface

// ===== sv/pearson_correlation_beta_unit.sv =====
// Pearson correlation / beta unit: a sample-pair request is added into the group sums as it is
// accepted, so pairs stream in back to back; a finish request is queued (two groups deep) and
// worked out by a back end that runs bit-serially: six (beta) or eight (correlation)
// shift-and-add products, each running over the significant bits of its first operand (at most
// 2*(SAMPLE_BITS + COUNT_BITS) bits), a 48-step restoring division and, for correlation, a
// 24-step square root; a group with fewer than two pairs skips all of these. Pairs keep being
// accepted meanwhile unless both queue slots hold groups still waiting. The result is signed
// Q8.16, saturated; mode 0 gives correlation, mode 1 gives beta, written at register address 0.
module pearson_correlation_beta_unit #(
   parameter int COUNT_BITS  = pcb_pkg::COUNT_BITS_DEF,
   parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pcb_req_if.sink                            req_chan,
   pcb_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcb_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pcb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pcb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import pcb_pkg::*;

   localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int SQ_W    = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int CR_W    = 2 * SAMPLE_BITS + COUNT_BITS + 1;
   localparam int ENTRY_W = 2 * SUM_W + 2 * SQ_W + CR_W + COUNT_BITS + 1;

   logic               mode_ff, mode_in;
   logic [ENTRY_W-1:0] push_entry, pop_entry;
   queue_ctrl_type     q_ctrl_in, q_ctrl_out;
   logic               push, pop;

   // Configuration register write and read back
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MODE) ? CSR_DATA_BITS'(mode_ff) : '0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MODE) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CORR;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      q_ctrl_in      = '0;
      q_ctrl_in.push = push;
      q_ctrl_in.pop  = pop;
   end

   pcb_front #(
      .COUNT_BITS (COUNT_BITS),
      .SAMPLE_BITS(SAMPLE_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (q_ctrl_out.full),
      .queue_push (push),
      .queue_entry(push_entry)
   );

   pcb_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (q_ctrl_in),
      .ctrl_out(q_ctrl_out),
      .wr_data (push_entry),
      .rd_data (pop_entry)
   );

   pcb_back #(
      .COUNT_BITS (COUNT_BITS),
      .SAMPLE_BITS(SAMPLE_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .queue_empty(q_ctrl_out.empty),
      .queue_pop  (pop),
      .queue_entry(pop_entry),
      .rsp        (rsp_chan)
   );

endmodule

// ===== sv/pcb_front.sv =====
// Front end: accepts requests, accumulates sample pairs, queues finished groups.
module pcb_front #(
   parameter int COUNT_BITS  = pcb_pkg::COUNT_BITS_DEF,
   parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_W     = 1
) (
   input  logic               clock,
   input  logic               reset,
   pcb_req_if.sink            req,
   input  logic               queue_full,
   output logic               queue_push,
   output logic [ENTRY_W-1:0] queue_entry
);
   import pcb_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int CR_W  = 2 * SAMPLE_BITS + COUNT_BITS + 1;
   localparam int PR_W  = 2 * SAMPLE_BITS;

   logic signed [SUM_W-1:0]      sa_ff, sa_in, sb_ff, sb_in;
   logic        [SQ_W-1:0]       saa_ff, saa_in, sbb_ff, sbb_in;
   logic signed [CR_W-1:0]       sab_ff, sab_in;
   logic        [COUNT_BITS-1:0] count_ff, count_in;
   logic                         drop_ff, drop_in;
   logic                         accept, pair, at_limit;
   logic signed [PR_W-1:0]       prod_aa, prod_bb, prod_ab;

   // Hold off requests only while the queue has no room
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign pair      = (req.kind == KIND_ADD) && req.a_present && req.b_present;
   assign at_limit  = (count_ff == {COUNT_BITS{1'b1}});

   assign prod_aa = req.sample_a * req.sample_a;
   assign prod_bb = req.sample_b * req.sample_b;
   assign prod_ab = req.sample_a * req.sample_b;

   // Snapshot the group into the queue on a finish request
   assign queue_push  = accept && (req.kind == KIND_FINISH);
   assign queue_entry = {drop_ff, count_ff, sab_ff, sbb_ff, saa_ff, sb_ff, sa_ff};

   // Accumulate, drop at the count limit, clear after a finish
   always_comb begin
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      saa_in   = saa_ff;
      sbb_in   = sbb_ff;
      sab_in   = sab_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      if (queue_push) begin
         sa_in    = '0;
         sb_in    = '0;
         saa_in   = '0;
         sbb_in   = '0;
         sab_in   = '0;
         count_in = '0;
         drop_in  = 1'b0;
      end else if (accept && pair) begin
         if (at_limit) begin
            drop_in = 1'b1;
         end else begin
            sa_in    = sa_ff + SUM_W'(req.sample_a);
            sb_in    = sb_ff + SUM_W'(req.sample_b);
            saa_in   = saa_ff + SQ_W'($unsigned(prod_aa));
            sbb_in   = sbb_ff + SQ_W'($unsigned(prod_bb));
            sab_in   = sab_ff + CR_W'(prod_ab);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff    <= '0;
         sb_ff    <= '0;
         saa_ff   <= '0;
         sbb_ff   <= '0;
         sab_ff   <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         sa_ff    <= sa_in;
         sb_ff    <= sb_in;
         saa_ff   <= saa_in;
         sbb_ff   <= sbb_in;
         sab_ff   <= sab_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ===== sv/pcb_queue.sv =====
// Short register queue carrying finished groups from front end to back end.
module pcb_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = pcb_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pcb_pkg::queue_ctrl_type ctrl_in,
   output pcb_pkg::queue_ctrl_type ctrl_out,
   input  logic [WIDTH-1:0]       wr_data,
   output logic [WIDTH-1:0]       rd_data
);
   import pcb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign do_push = ctrl_in.push && (fill_ff != CNT_W'(DEPTH));
   assign do_pop  = ctrl_in.pop && (fill_ff != '0);

   always_comb begin
      ctrl_out       = '0;
      ctrl_out.full  = (fill_ff == CNT_W'(DEPTH));
      ctrl_out.empty = (fill_ff == '0);
   end

   assign rd_data = mem[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== sv/pcb_back.sv =====
// Back end: serial multiplier, restoring divider and bitwise square root.
module pcb_back #(
   parameter int COUNT_BITS  = pcb_pkg::COUNT_BITS_DEF,
   parameter int SAMPLE_BITS = pcb_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_W     = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               mode,
   input  logic               queue_empty,
   output logic               queue_pop,
   input  logic [ENTRY_W-1:0] queue_entry,
   pcb_rsp_if.source          rsp
);
   import pcb_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int CR_W  = 2 * SAMPLE_BITS + COUNT_BITS + 1;
   localparam int MAGW  = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
   localparam int PW    = 2 * MAGW;
   localparam int XW    = PW + QUOT_BITS;
   localparam int CNT_W = $clog2(QUOT_BITS);
   localparam int OFF_SB  = SUM_W;
   localparam int OFF_SAA = 2 * SUM_W;
   localparam int OFF_SBB = OFF_SAA + SQ_W;
   localparam int OFF_SAB = OFF_SBB + SQ_W;
   localparam int OFF_CNT = OFF_SAB + CR_W;
   localparam int OFF_DRP = OFF_CNT + COUNT_BITS;
   localparam logic [QUOT_BITS-1:0] POS_MAX = QUOT_BITS'((1 << (RESULT_BITS - 1)) - 1);
   localparam logic [QUOT_BITS-1:0] NEG_MAX = QUOT_BITS'(1 << (RESULT_BITS - 1));

   back_state_type state_ff, state_in;

   logic        [2:0]            step_ff, step_in;
   logic        [COUNT_BITS-1:0] n_ff, n_in;
   logic signed [SUM_W-1:0]      sa_ff, sa_in, sb_ff, sb_in;
   logic        [SQ_W-1:0]       saa_ff, saa_in, sbb_ff, sbb_in;
   logic signed [CR_W-1:0]       sab_ff, sab_in;
   logic                         drop_ff, drop_in;
   logic        [MAGW-1:0]       mul_a_ff, mul_a_in;
   logic        [PW-1:0]         mul_b_ff, mul_b_in, acc_ff, acc_in;
   logic                         neg_ff, neg_in;
   logic signed [PW:0]           t_ff, t_in, num_ff, num_in, da_ff, da_in;
   logic        [PW-1:0]         den_ff, den_in;
   logic        [XW-1:0]         rem_ff, rem_in, dsh_ff, dsh_in;
   logic        [QUOT_BITS-1:0]  quo_ff, quo_in, root_ff, root_in, one_ff, one_in;
   logic        [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_data_ff, rsp_data_in;
   rsp_payload_type              res_ff, res_in;

   logic                         out_free, few_pairs, mul_done, div_ge, sqrt_ge;
   logic signed [PW:0]           prod, diff;
   logic        [MAGW-1:0]       abs_sa, abs_sb, abs_sab, mag;
   logic        [MAGW-1:0]       op_a;
   logic        [PW-1:0]         op_b;
   logic                         op_neg;
   logic        [QUOT_BITS-1:0]  sqrt_sum, q_mag;
   logic        [XW-1:0]         den_top;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign few_pairs = (n_ff < COUNT_BITS'(2));
   assign mul_done  = (mul_a_ff == '0);
   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty;

   assign abs_sa  = MAGW'(sa_ff < 0 ? -sa_ff : sa_ff);
   assign abs_sb  = MAGW'(sb_ff < 0 ? -sb_ff : sb_ff);
   assign abs_sab = MAGW'(sab_ff < 0 ? -sab_ff : sab_ff);
   assign mag     = MAGW'(num_ff < 0 ? -num_ff : num_ff);

   assign prod     = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
   assign diff     = t_ff - prod;
   assign den_top  = XW'(den_ff) << QUOT_BITS;
   assign div_ge   = (dsh_ff <= rem_ff);
   assign sqrt_sum = root_ff + one_ff;
   assign sqrt_ge  = (quo_ff >= sqrt_sum);
   assign q_mag    = (mode == MODE_CORR) ? root_ff : quo_ff;

   // Select the operands of each product in the finish sequence
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      case (step_ff)
         3'd0: begin
            op_a   = MAGW'(n_ff);
            op_b   = PW'(abs_sab);
            op_neg = sab_ff < 0;
         end
         3'd1: begin
            op_a   = abs_sa;
            op_b   = PW'(abs_sb);
            op_neg = (sa_ff < 0) != (sb_ff < 0);
         end
         3'd2: begin
            op_a = MAGW'(n_ff);
            op_b = PW'(saa_ff);
         end
         3'd3: begin
            op_a = abs_sa;
            op_b = PW'(abs_sa);
         end
         3'd4: begin
            op_a = MAGW'(n_ff);
            op_b = PW'(sbb_ff);
         end
         3'd5: begin
            op_a = abs_sb;
            op_b = PW'(abs_sb);
         end
         3'd6: begin
            op_a = mag;
            op_b = PW'(mag);
         end
         default: begin
            // t holds the benchmark variance from step five
            op_a = MAGW'(da_ff);
            op_b = PW'(t_ff);
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = few_pairs ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               if (step_ff == 3'd7 || (step_ff == 3'd5 && mode == MODE_BETA)) begin
                  state_in = ST_SAT;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SAT: begin
            if (den_ff == '0 || den_top <= rem_ff) begin
               state_in = (mode == MODE_CORR && den_ff != '0) ? ST_SQRT : ST_FINAL;
               if (den_ff == '0) begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = (mode == MODE_CORR) ? ST_SQRT : ST_FINAL;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      step_in      = step_ff;
      n_in         = n_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      saa_in       = saa_ff;
      sbb_in       = sbb_ff;
      sab_in       = sab_ff;
      drop_in      = drop_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      t_in         = t_ff;
      num_in       = num_ff;
      da_in        = da_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      one_in       = one_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            // Take the next finished group
            step_in = '0;
            n_in    = queue_entry[OFF_CNT +: COUNT_BITS];
            sa_in   = queue_entry[0 +: SUM_W];
            sb_in   = queue_entry[OFF_SB +: SUM_W];
            saa_in  = queue_entry[OFF_SAA +: SQ_W];
            sbb_in  = queue_entry[OFF_SBB +: SQ_W];
            sab_in  = queue_entry[OFF_SAB +: CR_W];
            drop_in = queue_entry[OFF_DRP];
            res_in.result       = '0;
            res_in.result_valid = 1'b0;
         end
         ST_LOAD: begin
            mul_a_in = op_a;
            mul_b_in = op_b;
            neg_in   = op_neg;
            acc_in   = '0;
            res_in.samples_dropped = drop_ff;
         end
         ST_MUL: begin
            if (mul_done) begin
               step_in = step_ff + 1'b1;
               case (step_ff)
                  3'd1: num_in = diff;
                  3'd3: da_in  = diff;
                  3'd5: begin
                     if (mode == MODE_BETA) begin
                        den_in = PW'(diff);
                        rem_in = XW'(mag) << FRAC_BITS;
                     end else begin
                        mul_b_in = PW'(diff);
                     end
                  end
                  3'd6: rem_in = XW'(acc_ff) << (2 * FRAC_BITS);
                  3'd7: den_in = acc_ff;
                  default: t_in = prod;
               endcase
               if (step_ff == 3'd5) begin
                  t_in = diff;
               end
            end else begin
               // Shift-and-add one multiplier bit
               if (mul_a_ff[0]) begin
                  acc_in = acc_ff + mul_b_ff;
               end
               mul_a_in = mul_a_ff >> 1;
               mul_b_in = mul_b_ff << 1;
            end
         end
         ST_SAT: begin
            quo_in  = '0;
            dsh_in  = XW'(den_ff) << (QUOT_BITS - 1);
            cnt_in  = CNT_W'(QUOT_BITS - 1);
            root_in = '0;
            one_in  = QUOT_BITS'(1) << (QUOT_BITS - 2);
            if (den_ff == '0) begin
               res_in.result       = '0;
               res_in.result_valid = (mode == MODE_CORR);
            end else if (den_top <= rem_ff) begin
               quo_in = '1;
               cnt_in = CNT_W'(ROOT_BITS - 1);
            end
         end
         ST_DIV: begin
            // One restoring division step
            quo_in = {quo_ff[QUOT_BITS-2:0], div_ge};
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = (cnt_ff == '0) ? CNT_W'(ROOT_BITS - 1) : cnt_ff - 1'b1;
         end
         ST_SQRT: begin
            // One bit of the integer square root
            if (sqrt_ge) begin
               quo_in  = quo_ff - sqrt_sum;
               root_in = (root_ff >> 1) + one_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            one_in = one_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
         end
         ST_FINAL: begin
            // Saturate and apply the sign of the numerator
            res_in.result_valid = 1'b1;
            if (num_ff < 0) begin
               res_in.result = RESULT_BITS'(-(q_mag > NEG_MAX ? NEG_MAX : q_mag));
            end else begin
               res_in.result = RESULT_BITS'(q_mag > POS_MAX ? POS_MAX : q_mag);
            end
         end
         ST_DONE: begin
            // Hand the finished result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result          = rsp_data_ff.result;
   assign rsp.result_valid    = rsp_data_ff.result_valid;
   assign rsp.samples_dropped = rsp_data_ff.samples_dropped;

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      n_ff        <= n_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      saa_ff      <= saa_in;
      sbb_ff      <= sbb_in;
      sab_ff      <= sab_in;
      drop_ff     <= drop_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      t_ff        <= t_in;
      num_ff      <= num_in;
      da_ff       <= da_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      root_ff     <= root_in;
      one_ff      <= one_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== tb/pearson_correlation_beta_unit_tb.sv =====
// Self-checking testbench of the correlation / beta unit with its own exact-arithmetic predictor.
module pearson_correlation_beta_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcb_pkg::*;

   localparam int          PAIR_LIMIT  = (1 << COUNT_BITS_DEF) - 1;
   localparam int          SETTLE      = 1000;
   localparam longint      CYCLE_LIMIT = 6000000;

   typedef logic signed [255:0] wide_t;

   typedef struct {
      logic        kind;
      logic [15:0] sample_a;
      logic [15:0] sample_b;
      logic        a_present;
      logic        b_present;
   } pair_req_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   pcb_req_if req_if ();
   pcb_rsp_if rsp_if ();

   pearson_correlation_beta_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   pair_req_t       pending_q[$];
   rsp_payload_type result_q[$];
   int  send_idle_pct = 0, recv_stall_pct = 0;
   int  mismatches = 0, results_seen = 0, requests_sent = 0;
   longint cycles = 0;

   // predictor state: exact group sums and the mode register
   wide_t sum_a, sum_b, sum_aa, sum_bb, sum_ab;
   int    n_pairs = 0;
   bit    dropped = 0;
   logic  mode_reg = MODE_CORR;

   function automatic void clear_group();
      sum_a = '0; sum_b = '0; sum_aa = '0; sum_bb = '0; sum_ab = '0;
      n_pairs = 0;
      dropped = 0;
   endfunction

   // exact result of a finished group
   function automatic rsp_payload_type group_result();
      rsp_payload_type r;
      wide_t nw, num, da, db, mag, den, target, cand, lhs;
      logic [23:0] q;
      bit have;
      nw = n_pairs;
      num = nw * sum_ab - sum_a * sum_b;
      da  = nw * sum_aa - sum_a * sum_a;
      db  = nw * sum_bb - sum_b * sum_b;
      mag = (num < 0) ? -num : num;
      q = '0;
      have = 0;
      r.result_valid = 1'b0;
      if (n_pairs >= 2) begin
         if (mode_reg == MODE_CORR) begin
            den = da * db;
            target = (mag * mag) <<< 32;
            r.result_valid = 1'b1;
            have = (den != 0);
         end else begin
            den = db;
            target = mag <<< 16;
            r.result_valid = (db != 0);
            have = (db != 0);
         end
         if (have) begin
            for (int bit_i = 23; bit_i >= 0; bit_i--) begin
               cand = wide_t'(q | (24'd1 << bit_i));
               lhs = (mode_reg == MODE_CORR) ? cand * cand * den : cand * den;
               if (lhs <= target) q = q | (24'd1 << bit_i);
            end
         end
      end
      // saturate and apply the sign of the numerator
      if (!have) r.result = '0;
      else if (num < 0) r.result = (q > 24'h800000) ? 24'h800000 : -q;
      else r.result = (q > 24'h7FFFFF) ? 24'h7FFFFF : q;
      r.samples_dropped = dropped;
      return r;
   endfunction

   function automatic void absorb_request(pair_req_t it);
      wide_t x, y;
      if (it.kind == KIND_FINISH) begin
         result_q.push_back(group_result());
         clear_group();
      end else if (it.a_present && it.b_present) begin
         if (n_pairs >= PAIR_LIMIT) begin
            dropped = 1;
         end else begin
            x = wide_t'(signed'(it.sample_a));
            y = wide_t'(signed'(it.sample_b));
            sum_a += x; sum_b += y;
            sum_aa += x * x; sum_bb += y * y; sum_ab += x * y;
            n_pairs++;
         end
      end
   endfunction

   // driver: hold a request until accepted, then fetch the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.kind <= KIND_ADD;
         req_if.sample_a <= '0;
         req_if.sample_b <= '0;
         req_if.a_present <= 1'b0;
         req_if.b_present <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_request('{req_if.kind, req_if.sample_a, req_if.sample_b,
                             req_if.a_present, req_if.b_present});
            requests_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               pair_req_t nx;
               nx = pending_q.pop_front();
               req_if.valid <= 1'b1;
               req_if.kind <= nx.kind;
               req_if.sample_a <= nx.sample_a;
               req_if.sample_b <= nx.sample_b;
               req_if.a_present <= nx.a_present;
               req_if.b_present <= nx.b_present;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %h valid %b dropped %b", rsp_if.result,
                           rsp_if.result_valid, rsp_if.samples_dropped);
            end else begin
               rsp_payload_type e;
               e = result_q.pop_front();
               if (rsp_if.result !== e.result || rsp_if.result_valid !== e.result_valid ||
                   rsp_if.samples_dropped !== e.samples_dropped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%b/%b got %h/%b/%b", e.result,
                              e.result_valid, e.samples_dropped, rsp_if.result,
                              rsp_if.result_valid, rsp_if.samples_dropped);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_mode(logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= REG_MODE; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      mode_reg = value[0];
   endtask

   // wait until every request is taken and every result is back
   task automatic drain();
      while (pending_q.size() > 0 || req_if.valid || result_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push(logic kind, logic [15:0] a, logic [15:0] b, logic ap = 1, logic bp = 1);
      pending_q.push_back('{kind, a, b, ap, bp});
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   // random group: mostly complete pairs, a few with a missing half
   task automatic random_group(int max_pairs);
      int np;
      np = $urandom_range(max_pairs);
      for (int i = 0; i < np; i++) begin
         if ($urandom_range(9) == 0) push(KIND_ADD, rand_sample(), rand_sample(),
                                          1'($urandom), 1'($urandom));
         else push(KIND_ADD, rand_sample(), rand_sample());
      end
      push(KIND_FINISH, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int counts[4] = '{0, 66, 0, 8};
      int stalls[4] = '{0, 0, 66, 8};
      int budget;
      clear_group();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, correlation: empty group, single pair, missing half, extremes, flat series
      write_mode(32'hFFFF_FFFE);
      push(KIND_FINISH, 0, 0);
      push(KIND_ADD, 16'h7FFF, 16'h8000);
      push(KIND_FINISH, 0, 0);
      push(KIND_ADD, 16'h1234, 16'h4321, 1, 0);
      push(KIND_ADD, 16'h1234, 16'h4321, 0, 1);
      push(KIND_ADD, 16'h7FFF, 16'h8000);
      push(KIND_ADD, 16'h8000, 16'h7FFF);
      push(KIND_ADD, 16'h0000, 16'h0000);
      push(KIND_FINISH, 0, 0);
      push(KIND_ADD, 16'd5, 16'd1);
      push(KIND_ADD, 16'd5, 16'd2);
      push(KIND_FINISH, 0, 0);
      drain();
      // directed, beta: flat benchmark, saturation both ways
      write_mode(32'h0000_0001);
      push(KIND_ADD, 16'd1, 16'd3);
      push(KIND_ADD, 16'd2, 16'd3);
      push(KIND_FINISH, 0, 0);
      push(KIND_ADD, 16'h7FFF, 16'd1);
      push(KIND_ADD, 16'h8000, 16'd0);
      push(KIND_FINISH, 0, 0);
      push(KIND_ADD, 16'h8000, 16'd1);
      push(KIND_ADD, 16'h7FFF, 16'd0);
      push(KIND_FINISH, 0, 0);
      drain();

      // random phases over each idling pattern and both modes
      for (int ph = 0; ph < 8; ph++) begin
         write_mode({31'($urandom), 1'(ph % 2)});
         send_idle_pct = counts[ph / 2];
         recv_stall_pct = stalls[ph / 2];
         budget = 95;
         while (budget > 0) begin
            int before_n;
            before_n = pending_q.size();
            random_group(($urandom_range(9) == 0) ? 60 : 14);
            budget -= pending_q.size() - before_n;
         end
         drain();
      end

      $display("covered %0d requests and %0d results over both modes and four idling patterns,",
               requests_sent, results_seen);
      $display("including empty, flat, half-missing and saturating groups");
      if (mismatches == 0 && result_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, result_q.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule
